[src/ptars_pkg.sv]
// shared types, constants and the arctangent table for the range scan block
// no dependencies; imported by every module of the block
`default_nettype none

package ptars_pkg;

    // fixed field widths
    localparam int COORD_WIDTH = 16;
    localparam int RANGE_W     = 16;
    localparam int BIN_NUM_W   = 11;
    localparam int SQRT_STEPS  = 16;
    localparam int ANG_W       = 33;

    localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 16'd8192;

    // request modes
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // register index decoded from paddr[2]
    localparam logic REG_MAX_RANGE = 1'b0;

    typedef struct packed {
        logic [1:0]             mode;
        logic [COORD_WIDTH-1:0] point_x;
        logic [COORD_WIDTH-1:0] point_y;
        logic                   point_valid;
        logic [BIN_NUM_W-1:0]   read_bin;
    } t_in;

    typedef struct packed {
        logic [BIN_NUM_W-1:0] bin_number;
        logic [RANGE_W-1:0]   bin_range;
        logic                 bin_hit;
    } t_out;

    // operand selection for the shared multiplier
    typedef enum logic [1:0] {
        MUL_X_SQ   = 2'd0,
        MUL_Y_SQ   = 2'd1,
        MUL_LIM_SQ = 2'd2,
        MUL_BIN    = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sum_en;
        logic     iter_init;
        logic     iter_en;
        logic     angle_en;
        logic     bin_rd;
        logic     upd_en;
        logic     rd_rd;
        logic     sweep_en;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic over_lim;
        logic iter_last;
        logic sweep_last;
        logic out_free;
    } t_status;

    // arctangent of 2^-i, 2^32 units per turn
    function automatic logic [31:0] atan_unit(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[src/ptars_ctrl.sv]
// sequencer for the range scan block: decodes requests and steps the datapath
// depends on ptars_pkg for command and status structs
`default_nettype none

module ptars_ctrl
    import ptars_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic [1:0] i_mode,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [13:0] {
        S_INIT    = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_CLEAR   = 14'b00000000000100,
        S_MUL_X   = 14'b00000000001000,
        S_MUL_Y   = 14'b00000000010000,
        S_MUL_LIM = 14'b00000000100000,
        S_CHECK   = 14'b00000001000000,
        S_ITER    = 14'b00000010000000,
        S_ANGLE   = 14'b00000100000000,
        S_BIN_MUL = 14'b00001000000000,
        S_BIN     = 14'b00010000000000,
        S_UPDATE  = 14'b00100000000000,
        S_RD      = 14'b01000000000000,
        S_RD_OUT  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep_en = 1'b1;
                if (i_status.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_mode)
                        MODE_CLEAR: n_state = S_CLEAR;
                        MODE_POINT: n_state = S_MUL_X;
                        MODE_READ:  n_state = S_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.sweep_en = 1'b1;
                if (i_status.sweep_last) n_state = S_IDLE;
            end
            S_MUL_X: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_X_SQ;
                n_state = i_status.skip ? S_IDLE : S_MUL_Y;
            end
            S_MUL_Y: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_Y_SQ;
                n_state = S_MUL_LIM;
            end
            S_MUL_LIM: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LIM_SQ;
                o_cmd.sum_en  = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.over_lim) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.iter_init = 1'b1;
                    n_state = S_ITER;
                end
            end
            S_ITER: begin
                o_cmd.iter_en = 1'b1;
                if (i_status.iter_last) n_state = S_ANGLE;
            end
            S_ANGLE: begin
                o_cmd.angle_en = 1'b1;
                n_state = S_BIN_MUL;
            end
            S_BIN_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_BIN;
                n_state = S_BIN;
            end
            S_BIN: begin
                o_cmd.bin_rd = 1'b1;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.upd_en = 1'b1;
                n_state = S_IDLE;
            end
            S_RD: begin
                o_cmd.rd_rd = 1'b1;
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[src/ptars_dp.sv]
// datapath: shared multiplier, cordic bearing, bitwise square root, bin memory
// depends on ptars_pkg; driven by ptars_ctrl through t_cmd and t_status
`default_nettype none

module ptars_dp
    import ptars_pkg::*;
#(
    parameter int NUM_BINS     = 1440,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_in                i_in_data,
    input  wire logic [RANGE_W-1:0] i_max_range,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output t_out                    o_out_data,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status
);

    localparam int BW   = $clog2(NUM_BINS);
    localparam int CW   = COORD_WIDTH + CORDIC_STEPS + 3;
    localparam int NIT  = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int CNTW = $clog2(NIT);
    localparam int PW   = 49;

    t_in                     r_in;
    logic [PW-1:0]           r_prod;
    logic [31:0]             r_acc;
    logic [32:0]             r_d2;
    logic signed [CW-1:0]    r_cx, r_cy;
    logic signed [ANG_W-1:0] r_z;
    logic [32:0]             r_rem, r_res, r_bit;
    logic [CNTW-1:0]         r_cnt;
    logic [31:0]             r_uang;
    logic [BW-1:0]           r_bin;
    logic [BW-1:0]           r_sweep;
    logic [RANGE_W:0]        r_mem [NUM_BINS];
    logic [RANGE_W:0]        r_rdata;
    logic                    r_out_valid;
    t_out                    r_out;

    logic                    y_neg;
    logic [COORD_WIDTH-1:0]  ux;
    logic [COORD_WIDTH:0]    ysx, uy;
    logic [31:0]             mul_a;
    logic [16:0]             mul_b;
    logic signed [CW-1:0]    dx, dy;
    logic signed [ANG_W-1:0] at;
    logic [32:0]             sq_t;
    logic [30:0]             mag;
    logic [17:0]             bin_q;
    logic [BW-1:0]           bin_idx, rd_idx;
    logic [BW+10:0]          rb_x, on_x;
    logic [RANGE_W-1:0]      root, cur;
    logic                    hit, win;

    // operand magnitudes
    assign y_neg = r_in.point_y[COORD_WIDTH-1];
    assign ux    = r_in.point_x;
    assign ysx   = {r_in.point_y[COORD_WIDTH-1], r_in.point_y};
    assign uy    = y_neg ? (~ysx + 1'b1) : ysx;

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_X_SQ: begin
                mul_a = 32'(ux);
                mul_b = 17'(ux);
            end
            MUL_Y_SQ: begin
                mul_a = 32'(uy);
                mul_b = uy;
            end
            MUL_LIM_SQ: begin
                mul_a = 32'(i_max_range);
                mul_b = 17'(i_max_range);
            end
            default: begin
                mul_a = r_uang;
                mul_b = 17'(NUM_BINS);
            end
        endcase
    end

    // request payload, products and distance squared
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in_data;
        if (i_cmd.mul_en) r_prod <= PW'(mul_a) * PW'(mul_b);
        if (i_cmd.mul_en && i_cmd.mul_sel == MUL_Y_SQ) r_acc <= r_prod[31:0];
        if (i_cmd.sum_en) r_d2 <= 33'(r_acc) + 33'(r_prod[31:0]);
    end

    // cordic and square root step terms
    assign dx   = r_cy >>> r_cnt;
    assign dy   = r_cx >>> r_cnt;
    assign at   = $signed({1'b0, atan_unit(5'(r_cnt))});
    assign sq_t = r_res + r_bit;

    // iterative cordic vectoring and restoring square root
    always_ff @(posedge i_clk) begin
        if (i_cmd.iter_init) begin
            r_cx  <= $signed(CW'(ux) << CORDIC_STEPS);
            r_cy  <= $signed(CW'(uy) << CORDIC_STEPS);
            r_z   <= '0;
            r_rem <= r_d2;
            r_res <= '0;
            r_bit <= 33'd1 << 30;
            r_cnt <= '0;
        end else if (i_cmd.iter_en) begin
            r_cnt <= r_cnt + 1'b1;
            if (32'(r_cnt) < 32'(CORDIC_STEPS)) begin
                if (!r_cy[CW-1]) begin
                    r_cx <= r_cx + dx;
                    r_cy <= r_cy - dy;
                    r_z  <= r_z + at;
                end else begin
                    r_cx <= r_cx - dx;
                    r_cy <= r_cy + dy;
                    r_z  <= r_z - at;
                end
            end
            if (32'(r_cnt) < 32'(SQRT_STEPS)) begin
                if (r_rem >= sq_t) begin
                    r_rem <= r_rem - sq_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
    end

    // bearing magnitude with axis cases and clamp to 90 degrees
    always_comb begin
        if (uy == '0) begin
            mag = '0;
        end else if (ux == '0) begin
            mag = 31'd1 << 30;
        end else if (r_z[ANG_W-1]) begin
            mag = '0;
        end else if (r_z > $signed(ANG_W'(1) << 30)) begin
            mag = 31'd1 << 30;
        end else begin
            mag = r_z[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.angle_en) begin
            r_uang <= y_neg ? ((32'd1 << 30) - 32'(mag)) : ((32'd1 << 30) + 32'(mag));
        end
    end

    // bin index from scaled bearing, clamped to the last bin
    assign bin_q   = (r_prod[48:31] >= 18'(NUM_BINS)) ? 18'(NUM_BINS - 1) : r_prod[48:31];
    assign bin_idx = bin_q[BW-1:0];

    // read request bin, out of range reads the last bin
    assign rb_x   = (BW+11)'(r_in.read_bin);
    assign rd_idx = (rb_x >= (BW+11)'(NUM_BINS)) ? BW'(NUM_BINS - 1) : rb_x[BW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_rd) r_bin <= bin_idx;
        else if (i_cmd.rd_rd) r_bin <= rd_idx;
    end

    // update decision against current bin value
    assign root = r_res[RANGE_W-1:0];
    assign hit  = r_rdata[RANGE_W];
    assign cur  = hit ? r_rdata[RANGE_W-1:0] : i_max_range;
    assign win  = root < cur;

    // bin memory, one hit flag and one range per entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_en) begin
            r_mem[r_sweep] <= '0;
        end else if (i_cmd.upd_en && win) begin
            r_mem[r_bin] <= {1'b1, root};
        end
        if (i_cmd.bin_rd) r_rdata <= r_mem[bin_idx];
        else if (i_cmd.rd_rd) r_rdata <= r_mem[rd_idx];
    end

    // clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_en) begin
            r_sweep <= o_status.sweep_last ? '0 : r_sweep + 1'b1;
        end
    end

    // output register
    assign on_x = (BW+11)'(r_bin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.bin_number <= on_x[BIN_NUM_W-1:0];
            r_out.bin_range  <= cur;
            r_out.bin_hit    <= hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // status back to the sequencer
    assign o_status.skip       = !r_in.point_valid || r_in.point_x[COORD_WIDTH-1];
    assign o_status.over_lim   = r_d2 > {1'b0, r_prod[31:0]};
    assign o_status.iter_last  = r_cnt == CNTW'(NIT - 1);
    assign o_status.sweep_last = r_sweep == BW'(NUM_BINS - 1);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

[src/points_to_angular_range_scan.sv]
// Point request: three multiplies, range check, iterative cordic and root, bearing, bin multiply, read, update.
// Read request: bin memory read, then output register load once it is free; clear request: full memory sweep.
// One request at a time; input ready only while idle; output register decouples the result.
// Clear and reset sweep the bin memory one entry per cycle through its single write port.
// Reset: synchronous active low, then a clearing pass over every bin with input not ready.
// Top level: apb register, sequencer and datapath; depends on ptars_pkg, ptars_ctrl, ptars_dp
`default_nettype none

module points_to_angular_range_scan
    import ptars_pkg::*;
#(
    parameter int NUM_BINS     = 1440,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [RANGE_W-1:0] r_max_range;
    t_cmd               cmd;
    t_status            status;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= MAX_RANGE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_MAX_RANGE) begin
            r_max_range <= pwdata[RANGE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_RANGE) ? 32'(r_max_range) : 32'd0;
    assign pready = 1'b1;

    ptars_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_data.mode),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ptars_dp #(
        .NUM_BINS     (NUM_BINS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_max_range (r_max_range),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

`default_nettype wire

[src/ptars_chk.sv]
// port-level checker for the range scan block, bound to the top level
// depends on ptars_pkg for the payload structs
`default_nettype none

module ptars_chk
    import ptars_pkg::*;
#(
    parameter int NUM_BINS = 1440
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire t_in         i_in_data,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire t_out        o_out_data,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // no result right after reset
    a_rst_out: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

    // the clearing pass keeps input ready low right after reset
    a_rst_busy: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !o_in_ready)
        else $error("input ready during clearing pass");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // an empty bin reports the configured maximum range
    a_empty_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.bin_hit && paddr[2] == REG_MAX_RANGE
        |-> o_out_data.bin_range == prdata[RANGE_W-1:0])
        else $error("empty bin range differs from max range");

    // reported bin lies in range
    a_bin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.bin_number) < 32'(NUM_BINS))
        else $error("bin number out of range");

endmodule

bind points_to_angular_range_scan ptars_chk #(.NUM_BINS(NUM_BINS)) u_ptars_chk (.*);

`default_nettype wire

[dv/ptars_scoreboard.sv]
// checker for the range scan block: watches requests, results and register writes
// keeps its own bin table and compares each read result; depends on ptars_pkg
`default_nettype none

module ptars_scoreboard
    import ptars_pkg::*;
#(
    parameter int NUM_BINS     = 1440,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire t_in         i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire t_out        i_out_data,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output int               o_errors,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [RANGE_W-1:0] scan_range [NUM_BINS];
    logic               scan_hit   [NUM_BINS];
    logic [RANGE_W-1:0] limit_range;
    t_out               read_queue [$];

    assign o_pending = read_queue.size();

    // arctangent table, 2^32 units per turn
    function automatic longint arc_step(input int idx);
        case (idx)
            0: return 536870912;   1: return 316933406;   2: return 167458907;
            3: return 85004756;    4: return 42667331;    5: return 21354465;
            6: return 10679838;    7: return 5340245;     8: return 2670163;
            9: return 1335087;     10: return 667544;     11: return 333772;
            12: return 166886;     13: return 83443;      14: return 41722;
            15: return 20861;      16: return 10430;      17: return 5215;
            18: return 2608;       19: return 1304;       20: return 652;
            21: return 326;        22: return 163;        23: return 81;
            default: return 0;
        endcase
    endfunction

    // bearing of a first-quadrant point, 2^30 is a right angle
    function automatic longint bearing_of(input longint px, input longint py);
        longint cx, cy, z, dx, dy;
        int n;
        n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        z = 0;
        if (py == 0) return 0;
        if (px == 0) return longint'(1) << 30;
        cx = px <<< n;
        cy = py <<< n;
        for (int i = 0; i < n; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx; cy -= dy; z += arc_step(i);
            end else begin
                cx -= dx; cy += dy; z -= arc_step(i);
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(1) << 30)) z = longint'(1) << 30;
        return z;
    endfunction

    // distance squared stays below 2^32, so the root fits in 16 bits
    function automatic longint root_floor(input longint v);
        longint r;
        r = 0;
        for (longint b = longint'(1) << 20; b > 0; b >>= 1)
            if ((r + b) * (r + b) <= v) r += b;
        return r;
    endfunction

    // fold one point into the bin table
    task automatic add_point(input t_in req);
        longint px, py, ay, d2, ang, bin, rng, cur;
        px = longint'($signed(req.point_x));
        py = longint'($signed(req.point_y));
        if (px < 0) return;
        ay = (py < 0) ? -py : py;
        d2 = px * px + ay * ay;
        if (d2 > longint'(limit_range) * longint'(limit_range)) return;
        rng = root_floor(d2);
        ang = bearing_of(px, ay);
        if (py < 0) ang = -ang;
        bin = ((ang + (longint'(1) << 30)) * NUM_BINS) >>> 31;
        if (bin >= NUM_BINS) bin = NUM_BINS - 1;
        cur = scan_hit[bin] ? scan_range[bin] : limit_range;
        if (rng < cur) begin
            scan_range[bin] = rng[RANGE_W-1:0];
            scan_hit[bin] = 1'b1;
        end
    endtask

    // predict on requests, compare on results
    always @(posedge i_clk) begin
        t_out want;
        int b;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BINS; i++) begin
                scan_hit[i] = 1'b0;
                scan_range[i] = '0;
            end
            limit_range = MAX_RANGE_RESET;
            read_queue.delete();
            o_errors <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[2] == REG_MAX_RANGE)
                limit_range = i_pwdata[RANGE_W-1:0];
            if (i_out_valid && i_out_ready) begin
                if (read_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = read_queue.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: bin mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d",
                            $realtime, want.bin_number, want.bin_range, want.bin_hit,
                            i_out_data.bin_number, i_out_data.bin_range, i_out_data.bin_hit);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.mode)
                    MODE_CLEAR: for (int i = 0; i < NUM_BINS; i++) scan_hit[i] = 1'b0;
                    MODE_POINT: if (i_in_data.point_valid) add_point(i_in_data);
                    MODE_READ: begin
                        b = i_in_data.read_bin;
                        if (b >= NUM_BINS) b = NUM_BINS - 1;
                        want.bin_number = b[BIN_NUM_W-1:0];
                        want.bin_hit = scan_hit[b];
                        want.bin_range = scan_hit[b] ? scan_range[b] : limit_range;
                        read_queue.insert(read_queue.size(), want);
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[dv/points_to_angular_range_scan_test.sv]
// top of the range scan testbench: clock, reset, register writes and requests
// depends on ptars_pkg, the block and ptars_scoreboard
`default_nettype none

module points_to_angular_range_scan_test
    import ptars_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BINS = 1440;
    localparam int STALL_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_data;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic        pready;
    int          errors, pending;
    int          send_idle = 0, recv_idle = 0;
    int          quiet = 0;

    always #5 clk = ~clk;

    points_to_angular_range_scan DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ptars_scoreboard u_scoreboard (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    // receiver stalls at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    // watchdog on accepted traffic
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_limit(input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // one request through the handshake, with optional idle cycles first
    // valid stays high after acceptance until the next request or an idle cycle
    task automatic send(input t_in req);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic t_in make_req(input logic [1:0] m, input int x, input int y,
                                     input logic v, input int rb);
        t_in r;
        r.mode = m;
        r.point_x = x[15:0];
        r.point_y = y[15:0];
        r.point_valid = v;
        r.read_bin = rb[10:0];
        return r;
    endfunction

    // wait for all reads back, then cover the clearing tail
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (NUM_BINS + 40) @(posedge clk);
    endtask

    // random traffic: a mix of points, full-range points, reads, invalid modes and clears
    task automatic random_phase(input int count);
        t_in r;
        int k, mag;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            mag = ($urandom_range(3) == 0) ? 32767 : 9000;
            if (k < 55)
                r = make_req(MODE_POINT, $urandom_range(mag), int'($urandom_range(2 * mag)) - mag,
                             $urandom_range(9) != 0, 0);
            else if (k < 62)
                r = make_req(MODE_POINT, $urandom, $urandom, 1'($urandom), $urandom);
            else if (k < 95)
                r = make_req(MODE_READ, $urandom, $urandom, 1'($urandom),
                             ($urandom_range(9) == 0) ? $urandom_range(2047)
                                                      : $urandom_range(NUM_BINS - 1));
            else if (k < 97)
                r = make_req(2'd3, $urandom, $urandom, 1'($urandom), $urandom);
            else
                r = make_req(MODE_CLEAR, $urandom, $urandom, 1'($urandom), $urandom);
            send(r);
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        drain();

        // directed: field extremes and each corner case
        send(make_req(MODE_READ, 0, 0, 0, 0));
        send(make_req(MODE_POINT, 0, 0, 1, 0));
        send(make_req(MODE_READ, 0, 0, 0, 720));
        send(make_req(MODE_POINT, 0, 4000, 1, 0));
        send(make_req(MODE_POINT, 0, -4000, 1, 0));
        send(make_req(MODE_POINT, 3000, 0, 1, 0));
        send(make_req(MODE_POINT, 3000, 0, 1, 0));
        send(make_req(MODE_POINT, 8192, 0, 1, 0));
        send(make_req(MODE_POINT, -100, 50, 1, 0));
        send(make_req(MODE_POINT, 100, 100, 0, 0));
        send(make_req(MODE_POINT, 32767, 32767, 1, 0));
        send(make_req(MODE_POINT, 2000, -2000, 1, 0));
        send(make_req(MODE_READ, 0, 0, 0, 1439));
        send(make_req(MODE_READ, 0, 0, 0, 0));
        send(make_req(MODE_READ, 0, 0, 0, 720));
        send(make_req(MODE_READ, 0, 0, 0, 2047));
        send(make_req(MODE_READ, 0, 0, 0, 360));
        send(make_req(2'd3, -1, -1, 1, 2047));
        send(make_req(MODE_CLEAR, 0, 0, 0, 0));
        send(make_req(MODE_READ, 0, 0, 0, 720));
        drain();

        // max_range sweeps with idle mixes
        write_limit(16'hFFFF);
        random_phase(500);
        drain();
        write_limit(16'd0);
        send_idle = 74;
        send(make_req(MODE_POINT, 0, 0, 1, 0));
        send(make_req(MODE_READ, 0, 0, 0, 720));
        random_phase(300);
        drain();
        write_limit(16'd12000);
        send_idle = 0; recv_idle = 74;
        random_phase(500);
        drain();
        write_limit(16'd5000);
        send_idle = 19; recv_idle = 19;
        random_phase(500);
        drain();
        write_limit(16'd8192);
        send_idle = 0; recv_idle = 0;
        random_phase(200);
        drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
src/ptars_pkg.sv
src/ptars_ctrl.sv
src/ptars_dp.sv
src/points_to_angular_range_scan.sv
src/ptars_chk.sv
dv/ptars_scoreboard.sv
dv/points_to_angular_range_scan_test.sv
